### hdl/e2e_p1_pkg.sv
// Shared types, codes and the CRC-8 helper for the E2E profile 1 receive checker.
`timescale 1ns / 1ps

package e2e_p1_pkg;

  localparam logic [7:0] CRC_POLY = 8'h1D;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SOME_LOST = 3'd1,
    ST_REPEATED  = 3'd2,
    ST_WRONG_SEQ = 3'd3,
    ST_WRONG_CRC = 3'd4,
    ST_NO_NEW    = 3'd5,
    ST_INITIAL   = 3'd6
  } status_t;

  typedef enum logic [7:0] {
    REG_CRC_BYTE_POS = 8'd0,
    REG_CNT_BYTE_POS = 8'd1,
    REG_DATA_ID      = 8'd2,
    REG_MAX_DELTA    = 8'd3,
    REG_MAX_NO_NEW   = 8'd4,
    REG_CRC_START    = 8'd5,
    REG_CRC_XOR_OUT  = 8'd6
  } reg_idx_t;

  // One byte of an MSB-first CRC-8, no reflection.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### hdl/e2e_profile1_receive_check.sv
// E2E profile 1 receive checker: byte-wise CRC-8 check and counter classification.
`timescale 1ns / 1ps
//
// Bytes of a protected message enter on the in_ stream, one request per byte,
// with in_tlast on the final byte. A request with in_tuser set is a no-data
// event instead of a byte; its in_tdata is ignored. Each message end and each
// no-data event yields one result request on the out_ stream carrying the
// check status, the accumulated lost-message count and the received counter.
// Registers are written on the cfg_ port (index, 16-bit data) while the block
// is idle; the user must keep to this, as the block does not enforce it.
// Unknown indexes are ignored. Each request is processed in the cycle it is
// accepted, and its result is held in the output register from the next cycle.
// One byte is taken every cycle while in_tready is high; the rate is set by
// the single CRC-8 byte step feeding the result register. Bytes are taken
// whenever the output register is free or being emptied, whether or not they
// produce a result; otherwise in_tready drops until the waiting result is taken.
// Reset restores the register defaults, clears all counters, sets the status
// to initial and drops any partially received message.
module e2e_profile1_receive_check #(
  parameter int COUNTER_MAX   = 14,
  parameter int MAX_MSG_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] cmd: set for a no-data event
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [2:0] status, [18:3] lost_count,
                                  // [22:19] received_counter, [23] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import e2e_p1_pkg::*;

  localparam int IDX_W = (MAX_MSG_BYTES > 2) ? $clog2(MAX_MSG_BYTES) : 1;
  localparam int CMP_W = (IDX_W > 8) ? IDX_W : 8;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_MSG_BYTES - 1);
  localparam logic signed [5:0] CNT_WRAP = 6'(COUNTER_MAX + 1);

  // Configuration registers.
  logic [7:0]  crc_byte_pos_r, crc_byte_pos_nxt;
  logic [7:0]  cnt_byte_pos_r, cnt_byte_pos_nxt;
  logic [15:0] data_id_r, data_id_nxt;
  logic [3:0]  max_delta_r, max_delta_nxt;
  logic [7:0]  max_no_new_r, max_no_new_nxt;
  logic [7:0]  crc_start_r, crc_start_nxt;
  logic [7:0]  crc_xor_out_r, crc_xor_out_nxt;
  logic [7:0]  id_crc_r, id_crc_nxt;

  // Checker state.
  logic [IDX_W-1:0] byte_index_r, byte_index_nxt;
  logic [7:0]  running_crc_r, running_crc_nxt;
  logic [7:0]  captured_crc_r, captured_crc_nxt;
  logic [3:0]  captured_cnt_r, captured_cnt_nxt;
  logic [3:0]  last_good_cnt_r, last_good_cnt_nxt;
  logic        awaiting_first_r, awaiting_first_nxt;
  status_t     held_status_r, held_status_nxt;
  logic [15:0] lost_total_r, lost_total_nxt;
  logic [7:0]  no_new_cnt_r, no_new_cnt_nxt;

  logic        out_tvalid_r, out_tvalid_nxt;
  logic [23:0] out_tdata_r, out_tdata_nxt;

  logic        in_acc;
  logic        first_byte, at_crc, at_cnt, msg_end, crc_bad;
  logic [7:0]  crc_in, crc_step, crc_final, cap_crc, nn_inc;
  logic [3:0]  cap_cnt;
  logic [CMP_W-1:0] idx_ext, crc_pos_ext, cnt_pos_ext;
  logic signed [5:0] delta;

  assign in_tready  = !out_tvalid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Register writes; the DataID CRC is refreshed from the values being written
  // so that it is ready for the very next byte.
  always_comb begin
    crc_byte_pos_nxt = crc_byte_pos_r;
    cnt_byte_pos_nxt = cnt_byte_pos_r;
    data_id_nxt      = data_id_r;
    max_delta_nxt    = max_delta_r;
    max_no_new_nxt   = max_no_new_r;
    crc_start_nxt    = crc_start_r;
    crc_xor_out_nxt  = crc_xor_out_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_CRC_BYTE_POS: crc_byte_pos_nxt = cfg_data[7:0];
        REG_CNT_BYTE_POS: cnt_byte_pos_nxt = cfg_data[7:0];
        REG_DATA_ID:      data_id_nxt      = cfg_data;
        REG_MAX_DELTA:    max_delta_nxt    = cfg_data[3:0];
        REG_MAX_NO_NEW:   max_no_new_nxt   = cfg_data[7:0];
        REG_CRC_START:    crc_start_nxt    = cfg_data[7:0];
        REG_CRC_XOR_OUT:  crc_xor_out_nxt  = cfg_data[7:0];
        default: ;
      endcase
    end
    if (!rst_n) begin
      crc_byte_pos_nxt = 8'd0;
      cnt_byte_pos_nxt = 8'd1;
      data_id_nxt      = 16'd0;
      max_delta_nxt    = 4'd1;
      max_no_new_nxt   = 8'd1;
      crc_start_nxt    = 8'hFF;
      crc_xor_out_nxt  = 8'hFF;
    end
    id_crc_nxt = crc8_update(crc8_update(crc_start_nxt, data_id_nxt[15:8]), data_id_nxt[7:0])
                 ^ crc_xor_out_nxt;
  end

  always_comb begin
    byte_index_nxt     = byte_index_r;
    running_crc_nxt    = running_crc_r;
    captured_crc_nxt   = captured_crc_r;
    captured_cnt_nxt   = captured_cnt_r;
    last_good_cnt_nxt  = last_good_cnt_r;
    awaiting_first_nxt = awaiting_first_r;
    held_status_nxt    = held_status_r;
    lost_total_nxt     = lost_total_r;
    no_new_cnt_nxt     = no_new_cnt_r;
    out_tvalid_nxt     = out_tvalid_r && !out_tready;
    out_tdata_nxt      = out_tdata_r;

    idx_ext     = CMP_W'(byte_index_r);
    crc_pos_ext = CMP_W'(crc_byte_pos_r);
    cnt_pos_ext = CMP_W'(cnt_byte_pos_r);
    first_byte  = (byte_index_r == '0);
    at_crc      = (idx_ext == crc_pos_ext);
    at_cnt      = (idx_ext == cnt_pos_ext);
    msg_end     = in_tlast || (byte_index_r == LAST_IDX);

    // A new message starts from the DataID segment and forgets captured fields.
    crc_in  = first_byte ? id_crc_r : running_crc_r;
    cap_crc = first_byte ? 8'd0 : captured_crc_r;
    cap_cnt = first_byte ? 4'd0 : captured_cnt_r;

    // The CRC byte itself is skipped and closes the segment before it.
    if (at_crc) begin
      cap_crc  = in_tdata;
      crc_step = first_byte ? crc_in : (crc_in ^ crc_xor_out_r);
    end else begin
      crc_step = crc8_update(crc_in, in_tdata);
    end
    if (at_cnt) begin
      cap_cnt = in_tdata[3:0];
    end

    crc_final = (idx_ext > crc_pos_ext) ? (crc_step ^ crc_xor_out_r) : crc_step;
    crc_bad   = (idx_ext < crc_pos_ext) || (crc_final != cap_crc);

    if ({1'b0, cap_cnt} >= {1'b0, last_good_cnt_r}) begin
      delta = $signed({2'b00, cap_cnt}) - $signed({2'b00, last_good_cnt_r});
    end else begin
      delta = CNT_WRAP - $signed({2'b00, last_good_cnt_r}) + $signed({2'b00, cap_cnt});
    end

    nn_inc = (no_new_cnt_r == 8'hFF) ? no_new_cnt_r : no_new_cnt_r + 8'd1;

    if (in_acc) begin
      if (in_tuser) begin
        no_new_cnt_nxt = nn_inc;
        if (nn_inc >= max_no_new_r) begin
          held_status_nxt = ST_NO_NEW;
        end
        out_tvalid_nxt = 1'b1;
        out_tdata_nxt  = {1'b0, 4'd0, lost_total_r, held_status_nxt};
      end else begin
        captured_crc_nxt = cap_crc;
        captured_cnt_nxt = cap_cnt;
        if (!msg_end) begin
          running_crc_nxt = crc_step;
          byte_index_nxt  = byte_index_r + 1'b1;
        end else begin
          byte_index_nxt  = '0;
          running_crc_nxt = crc_final;
          if (crc_bad) begin
            held_status_nxt = ST_WRONG_CRC;
          end else begin
            no_new_cnt_nxt = 8'd0;
            if (awaiting_first_r) begin
              awaiting_first_nxt = 1'b0;
              last_good_cnt_nxt  = cap_cnt;
              held_status_nxt    = ST_INITIAL;
            end else if (delta == 6'sd0) begin
              held_status_nxt = ST_REPEATED;
            end else if (delta == 6'sd1) begin
              last_good_cnt_nxt = cap_cnt;
              held_status_nxt   = ST_OK;
            end else if (delta > 6'sd1 && delta <= $signed({2'b00, max_delta_r})) begin
              lost_total_nxt    = lost_total_r + 16'(delta[4:0] - 5'd1);
              last_good_cnt_nxt = cap_cnt;
              held_status_nxt   = ST_SOME_LOST;
            end else begin
              held_status_nxt = ST_WRONG_SEQ;
            end
          end
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {1'b0, cap_cnt, lost_total_nxt, held_status_nxt};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    crc_byte_pos_r <= crc_byte_pos_nxt;
    cnt_byte_pos_r <= cnt_byte_pos_nxt;
    data_id_r      <= data_id_nxt;
    max_delta_r    <= max_delta_nxt;
    max_no_new_r   <= max_no_new_nxt;
    crc_start_r    <= crc_start_nxt;
    crc_xor_out_r  <= crc_xor_out_nxt;
    id_crc_r       <= id_crc_nxt;
    out_tdata_r    <= out_tdata_nxt;
    if (!rst_n) begin
      byte_index_r     <= '0;
      running_crc_r    <= 8'd0;
      captured_crc_r   <= 8'd0;
      captured_cnt_r   <= 4'd0;
      last_good_cnt_r  <= 4'd0;
      awaiting_first_r <= 1'b1;
      held_status_r    <= ST_INITIAL;
      lost_total_r     <= 16'd0;
      no_new_cnt_r     <= 8'd0;
      out_tvalid_r     <= 1'b0;
    end else begin
      byte_index_r     <= byte_index_nxt;
      running_crc_r    <= running_crc_nxt;
      captured_crc_r   <= captured_crc_nxt;
      captured_cnt_r   <= captured_cnt_nxt;
      last_good_cnt_r  <= last_good_cnt_nxt;
      awaiting_first_r <= awaiting_first_nxt;
      held_status_r    <= held_status_nxt;
      lost_total_r     <= lost_total_nxt;
      no_new_cnt_r     <= no_new_cnt_nxt;
      out_tvalid_r     <= out_tvalid_nxt;
    end
  end

endmodule
